>>> rtl/ucfd_pkg.sv
// ----------------------------------------------------------------------------
// ucfd_pkg
// Shared types, constants and the DLC length table for the USB CAN deframer.
// ----------------------------------------------------------------------------
package ucfd_pkg;

    localparam logic [6:0] HDR_BYTES = 7'd6;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] arrival_time;
    } ucfd_in_t;

    typedef struct packed {
        logic        status;
        logic        fd_flag;
        logic [2:0]  bus_number;
        logic        rejected_flag;
        logic        returned_flag;
        logic [28:0] can_address;
        logic [6:0]  payload_length;
        logic [5:0]  byte_index;
        logic [7:0]  payload_byte;
        logic [31:0] frame_time;
        logic        last;
    } ucfd_out_t;

    typedef enum logic [1:0] {
        ST_RECV,
        ST_FRAME,
        ST_ERROR
    } ucfd_state_t;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_EMPTY,
        KIND_ERROR
    } ucfd_kind_t;

    localparam logic STATUS_DATA  = 1'b0;
    localparam logic STATUS_CKSUM = 1'b1;

    // CAN-FD DLC to payload length
    function automatic logic [6:0] dlc_len(input logic [3:0] dlc);
        logic [6:0] len;
        unique case (dlc)
            4'd9:    len = 7'd12;
            4'd10:   len = 7'd16;
            4'd11:   len = 7'd20;
            4'd12:   len = 7'd24;
            4'd13:   len = 7'd32;
            4'd14:   len = 7'd48;
            4'd15:   len = 7'd64;
            default: len = {3'b000, dlc};
        endcase
        return len;
    endfunction

endpackage

>>> rtl/usb_can_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// usb_can_frame_deframer_core
// Splits a USB byte stream into CAN packets, checks the XOR and emits frames.
// ----------------------------------------------------------------------------
//  channel   | valid        | stall        | payload
//  ----------+--------------+--------------+---------------------------------
//  byte in   | byte_valid   | byte_stall   | byte_req   (ucfd_in_t)
//  frame out | frame_valid  | frame_stall  | frame_res  (ucfd_out_t)
//
//  A packet with N payload bytes takes 6+N accepted bytes, one per cycle
//  while byte_stall is low. Emission then yields max(N,1) results, one per
//  cycle while the output queue has room, paced by the single read port of
//  the 64-entry payload memory; byte_stall is high for it. A checksum failure
//  yields one result. Reset clears the counters and the output queue; memory
//  contents are kept. frame_stall holds the output register and 1-entry skid.
// ----------------------------------------------------------------------------
module usb_can_frame_deframer_core
    import ucfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  ucfd_in_t  byte_req,
    output logic      frame_valid,
    input  logic      frame_stall,
    output ucfd_out_t frame_res
);

    logic [7:0] payload_mem [64];

    ucfd_state_t state_reg, state_next;
    logic [6:0]  byte_count_reg;
    logic [7:0]  xor_reg;
    logic [6:0]  len_reg;
    logic [5:0]  rd_idx_reg;
    logic [7:0]  hdr_reg [HDR_BYTES];
    logic [31:0] time_reg;
    logic [7:0]  rd_data_reg;

    logic        pend_valid_reg;
    ucfd_kind_t  pend_kind_reg;
    logic [5:0]  pend_idx_reg;
    logic        pend_last_reg;

    logic        out_valid_reg;
    ucfd_out_t   out_reg;
    logic        skid_valid_reg;
    ucfd_out_t   skid_reg;

    logic        byte_acc;
    logic        is_header;
    logic [6:0]  len_now;
    logic [6:0]  count_inc;
    logic [7:0]  xor_now;
    logic        complete;
    logic [6:0]  pay_off;

    logic        out_taken;
    logic [1:0]  occupancy;
    logic        slot_free;
    logic        issue;
    logic        issue_last;
    ucfd_kind_t  issue_kind;
    ucfd_out_t   pend_res;
    logic [31:0] hdr_word;

    assign byte_acc  = byte_valid && !byte_stall;
    assign is_header = byte_count_reg < HDR_BYTES;
    assign len_now   = (byte_count_reg == 7'd0) ? dlc_len(byte_req.data_byte[7:4]) : len_reg;
    assign count_inc = byte_count_reg + 7'd1;
    assign xor_now   = xor_reg ^ byte_req.data_byte;
    assign complete  = count_inc == (HDR_BYTES + len_now);
    assign pay_off   = byte_count_reg - HDR_BYTES;

    assign out_taken = out_valid_reg && !frame_stall;
    assign occupancy = {1'b0, out_valid_reg} + {1'b0, skid_valid_reg} + {1'b0, pend_valid_reg}
                       - {1'b0, out_taken};
    assign slot_free = occupancy < 2'd2;
    assign issue_last = (len_reg == 7'd0) || ({1'b0, rd_idx_reg} == (len_reg - 7'd1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RECV:
            begin
                if (byte_acc && complete)
                begin
                    state_next = (xor_now == 8'd0) ? ST_FRAME : ST_ERROR;
                end
            end
            ST_FRAME:
            begin
                if (slot_free && issue_last)
                begin
                    state_next = ST_RECV;
                end
            end
            ST_ERROR:
            begin
                if (slot_free)
                begin
                    state_next = ST_RECV;
                end
            end
            default: state_next = ST_RECV;
        endcase
    end

    // state outputs
    always_comb
    begin
        byte_stall = 1'b1;
        issue      = 1'b0;
        issue_kind = KIND_DATA;
        unique case (state_reg)
            ST_RECV:
            begin
                byte_stall = 1'b0;
            end
            ST_FRAME:
            begin
                issue      = slot_free;
                issue_kind = (len_reg == 7'd0) ? KIND_EMPTY : KIND_DATA;
            end
            ST_ERROR:
            begin
                issue      = slot_free;
                issue_kind = KIND_ERROR;
            end
            default: byte_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RECV;
            byte_count_reg <= 7'd0;
            xor_reg        <= 8'd0;
            len_reg        <= 7'd0;
            rd_idx_reg     <= 6'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= issue;
            if (byte_acc)
            begin
                len_reg <= len_now;
                if (complete)
                begin
                    byte_count_reg <= 7'd0;
                    xor_reg        <= 8'd0;
                    rd_idx_reg     <= 6'd0;
                end
                else
                begin
                    byte_count_reg <= count_inc;
                    xor_reg        <= xor_now;
                end
            end
            else if (issue && state_reg == ST_FRAME)
            begin
                rd_idx_reg <= rd_idx_reg + 6'd1;
            end

            // advance the output queue; skid is older than pending data
            if (out_taken)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= pend_valid_reg;
                end
                else
                begin
                    out_valid_reg <= pend_valid_reg;
                end
            end
            else if (pend_valid_reg)
            begin
                if (out_valid_reg)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    // payload registers of the queue
    always_ff @(posedge clk)
    begin
        if (out_taken)
        begin
            if (skid_valid_reg)
            begin
                out_reg  <= skid_reg;
                skid_reg <= pend_res;
            end
            else
            begin
                out_reg <= pend_res;
            end
        end
        else if (pend_valid_reg)
        begin
            if (out_valid_reg)
            begin
                skid_reg <= pend_res;
            end
            else
            begin
                out_reg <= pend_res;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_acc && is_header)
        begin
            hdr_reg[byte_count_reg[2:0]] <= byte_req.data_byte;
        end
        if (byte_acc && complete)
        begin
            time_reg <= byte_req.arrival_time;
        end
        if (issue)
        begin
            pend_kind_reg <= issue_kind;
            pend_idx_reg  <= rd_idx_reg;
            pend_last_reg <= (issue_kind == KIND_ERROR) || issue_last;
        end
    end

    // payload memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (byte_acc && !is_header)
        begin
            payload_mem[pay_off[5:0]] <= byte_req.data_byte;
        end
        if (issue)
        begin
            rd_data_reg <= payload_mem[rd_idx_reg];
        end
    end

    assign hdr_word = {hdr_reg[4], hdr_reg[3], hdr_reg[2], hdr_reg[1]};

    always_comb
    begin
        pend_res            = '0;
        pend_res.frame_time = time_reg;
        pend_res.last       = pend_last_reg;
        unique case (pend_kind_reg)
            KIND_ERROR:
            begin
                pend_res.status = STATUS_CKSUM;
            end
            KIND_EMPTY, KIND_DATA:
            begin
                pend_res.status        = STATUS_DATA;
                pend_res.fd_flag       = hdr_reg[0][0];
                pend_res.bus_number    = hdr_reg[0][3:1];
                pend_res.rejected_flag = hdr_reg[1][0];
                pend_res.returned_flag = hdr_reg[1][1];
                pend_res.can_address   = hdr_word[31:3];
                if (pend_kind_reg == KIND_DATA)
                begin
                    pend_res.payload_length = len_reg;
                    pend_res.byte_index     = pend_idx_reg;
                    pend_res.payload_byte   = rd_data_reg;
                end
            end
            default: pend_res.status = STATUS_CKSUM;
        endcase
    end

    assign frame_valid = out_valid_reg;
    assign frame_res   = out_reg;

endmodule

>>> rtl/ucfd_checker.sv
// ----------------------------------------------------------------------------
// ucfd_checker
// Port-level checks for the USB CAN deframer, bound to the top level.
// ----------------------------------------------------------------------------
module ucfd_checker
    import ucfd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      byte_valid,
    input logic      byte_stall,
    input ucfd_in_t  byte_req,
    input logic      frame_valid,
    input logic      frame_stall,
    input ucfd_out_t frame_res
);

    // hold a stalled byte request
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(byte_req))
        else $error("stalled byte request changed");

    // hold a stalled result request
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_stall |=> frame_valid && $stable(frame_res))
        else $error("stalled result changed");

    // a checksum failure is a lone, empty result
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_res.status == STATUS_CKSUM |->
            frame_res.last && frame_res.payload_length == 7'd0 &&
            frame_res.can_address == 29'd0 && frame_res.byte_index == 6'd0)
        else $error("malformed checksum result");

    // the last data result sits on the final payload byte
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_res.status == STATUS_DATA && frame_res.last &&
        frame_res.payload_length != 7'd0 |->
            {1'b0, frame_res.byte_index} == frame_res.payload_length - 7'd1)
        else $error("last flag off the final byte");

    // index stays inside the payload
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_res.status == STATUS_DATA &&
        frame_res.payload_length != 7'd0 |->
            {1'b0, frame_res.byte_index} < frame_res.payload_length)
        else $error("byte index beyond payload");

endmodule

bind usb_can_frame_deframer_core ucfd_checker u_ucfd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_req    (byte_req),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_res   (frame_res)
);

>>> verif/tb_usb_can_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// tb_usb_can_frame_deframer_core
// Self-checking bench for the USB CAN deframer. A byte-level predictor tracks
// header, payload, byte count and running XOR, and queues the frames each
// completed packet should produce. A short directed table hits the field
// extremes, an empty payload, a checksum failure and a one-byte payload.
// Random packets follow: mostly well-formed with random content, some with a
// flipped bit or a random check byte, and one with the largest payload.
// Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_usb_can_frame_deframer_core;
    import ucfd_pkg::*;

    localparam int RANDOM_BYTES = 145;
    localparam int DIRECTED_ROWS = 25;

    typedef struct packed {
        logic [7:0]  data;
        logic [31:0] stamp;
        logic        typed;
        ucfd_out_t   want;
    } directed_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_stall;
    ucfd_in_t  byte_req = '0;
    logic      frame_valid;
    logic      frame_stall = 1'b0;
    ucfd_out_t frame_res;

    // CAN-FD DLC to payload length
    logic [6:0] fd_len_table [16] = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7,
                                      7'd8, 7'd12, 7'd16, 7'd20, 7'd24, 7'd32, 7'd48,
                                      7'd64};

    // header 0F FF FF FF FF 0F: empty payload, every header field at its top value
    // header of zeros: empty payload, every field zero
    // zeros then 5A: XOR is nonzero, checksum failure
    // DLC 1 with payload byte FF, checked by the predictor
    directed_row_t plan [DIRECTED_ROWS] = '{
        '{8'h0F, 32'h0000_0001, 1'b0, 90'd0},
        '{8'hFF, 32'h0000_0002, 1'b0, 90'd0},
        '{8'hFF, 32'h8000_0000, 1'b0, 90'd0},
        '{8'hFF, 32'h0000_0003, 1'b0, 90'd0},
        '{8'hFF, 32'h0000_0004, 1'b0, 90'd0},
        '{8'h0F, 32'hFFFF_FFFF, 1'b1,
            {STATUS_DATA, 1'b1, 3'd7, 1'b1, 1'b1, 29'h1FFF_FFFF, 7'd0, 6'd0, 8'h00,
             32'hFFFF_FFFF, 1'b1}},
        '{8'h00, 32'h0000_0010, 1'b0, 90'd0},
        '{8'h00, 32'h0000_0011, 1'b0, 90'd0},
        '{8'h00, 32'h0000_0012, 1'b0, 90'd0},
        '{8'h00, 32'h0000_0013, 1'b0, 90'd0},
        '{8'h00, 32'h0000_0014, 1'b0, 90'd0},
        '{8'h00, 32'h0000_0000, 1'b1,
            {STATUS_DATA, 1'b0, 3'd0, 1'b0, 1'b0, 29'd0, 7'd0, 6'd0, 8'h00,
             32'h0000_0000, 1'b1}},
        '{8'h00, 32'h0000_0020, 1'b0, 90'd0},
        '{8'h00, 32'h0000_0021, 1'b0, 90'd0},
        '{8'h00, 32'h0000_0022, 1'b0, 90'd0},
        '{8'h00, 32'h0000_0023, 1'b0, 90'd0},
        '{8'h00, 32'h0000_0024, 1'b0, 90'd0},
        '{8'h5A, 32'h1234_5678, 1'b1,
            {STATUS_CKSUM, 1'b0, 3'd0, 1'b0, 1'b0, 29'd0, 7'd0, 6'd0, 8'h00,
             32'h1234_5678, 1'b1}},
        '{8'h12, 32'h0000_0030, 1'b0, 90'd0},
        '{8'hA6, 32'h0000_0031, 1'b0, 90'd0},
        '{8'h5C, 32'h0000_0032, 1'b0, 90'd0},
        '{8'h81, 32'h0000_0033, 1'b0, 90'd0},
        '{8'h3E, 32'h0000_0034, 1'b0, 90'd0},
        '{8'hA8, 32'h0000_0035, 1'b0, 90'd0},
        '{8'hFF, 32'hA5A5_5A5A, 1'b0, 90'd0}
    };

    // predictor state
    logic [7:0] rx_header [6];
    logic [7:0] rx_payload [64];
    int         rx_count = 0;
    logic [7:0] rx_xor = 8'h00;
    logic [6:0] rx_len = 7'd0;

    ucfd_out_t expected_frames [$];
    ucfd_out_t want_frame;
    int        mismatches = 0;
    int        stall_left = 0;
    int        calm_left = 0;
    logic      calm = 1'b0;

    usb_can_frame_deframer_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_req    (byte_req),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_res   (frame_res)
    );

    always #5 clk = ~clk;

    initial
    begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // append one expected frame at the tail
    task automatic queue_frame(input ucfd_out_t f);
        expected_frames.insert(expected_frames.size(), f);
    endtask

    // Advance the packet state by one byte; queue the frames it completes.
    task automatic absorb_byte(input logic [7:0] b, input logic [31:0] t, input bit keep);
        ucfd_out_t  r;
        logic [31:0] word;
        if (rx_count < HDR_BYTES)
        begin
            rx_header[rx_count] = b;
            if (rx_count == 0)
                rx_len = fd_len_table[b[7:4]];
        end
        else
        begin
            rx_payload[(rx_count - HDR_BYTES) % 64] = b;
        end
        rx_count++;
        rx_xor ^= b;
        if (rx_count != HDR_BYTES + rx_len)
            return;

        r = '0;
        r.frame_time = t;
        r.last = 1'b1;
        if (rx_xor != 8'h00)
        begin
            r.status = STATUS_CKSUM;
            if (keep)
                queue_frame(r);
        end
        else
        begin
            word = {rx_header[4], rx_header[3], rx_header[2], rx_header[1]};
            r.status = STATUS_DATA;
            r.fd_flag = rx_header[0][0];
            r.bus_number = rx_header[0][3:1];
            r.rejected_flag = rx_header[1][0];
            r.returned_flag = rx_header[1][1];
            r.can_address = word[31:3];
            r.payload_length = rx_len;
            if (rx_len == 7'd0)
            begin
                if (keep)
                    queue_frame(r);
            end
            else
            begin
                for (int i = 0; i < rx_len; i++)
                begin
                    r.byte_index = i[5:0];
                    r.payload_byte = rx_payload[i];
                    r.last = (i == rx_len - 1);
                    if (keep)
                        queue_frame(r);
                end
            end
        end
        rx_count = 0;
        rx_xor = 8'h00;
        rx_len = 7'd0;
    endtask

    // Present one request, hold it until taken, then predict.
    task automatic send_byte(input logic [7:0] b, input logic [31:0] t, input bit keep);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_req <= '{data_byte: b, arrival_time: t};
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        absorb_byte(b, t, keep);
    endtask

    task automatic drain_frames();
        byte_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_frames.size() != 0);
    endtask

    // frame side: check accepted frames, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && frame_valid && !frame_stall)
        begin
            if (expected_frames.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected frame: expected none, got %h", $time, frame_res);
            end
            else
            begin
                want_frame = expected_frames.pop_front();
                if (want_frame !== frame_res)
                begin
                    mismatches++;
                    $display("%0t frame: expected %h, got %h", $time, want_frame,
                             frame_res);
                end
            end
        end
        if (stall_left > 0)
        begin
            frame_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            frame_stall <= 1'b0;
            stall_left = pick_gap();
        end
        // alternate busy and quiet stretches
        if (calm_left == 0)
        begin
            calm <= ~calm;
            calm_left <= $urandom_range(30, 300);
        end
        else
        begin
            calm_left <= calm_left - 1;
        end
    end

    initial
    begin
        logic [7:0] pkt [70];
        logic [7:0] sum;
        int         plen;
        int         sent;
        int         k;
        int         pos;
        int         kind;
        logic [3:0] dlc;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_byte(plan[i].data, plan[i].stamp, !plan[i].typed);
            if (plan[i].typed)
                queue_frame(plan[i].want);
        end
        drain_frames();

        sent = 0;
        k = 0;
        while (sent < RANDOM_BYTES)
        begin
            if (k == 3)
                dlc = 4'd15;
            else if ($urandom_range(0, 9) < 8)
                dlc = 4'($urandom_range(0, 8));
            else
                dlc = 4'($urandom_range(9, 14));
            plen = HDR_BYTES + fd_len_table[dlc];
            for (int i = 0; i < plen; i++)
                pkt[i] = 8'($urandom);
            pkt[0][7:4] = dlc;
            // make header byte 5 cancel the XOR of the rest
            sum = 8'h00;
            for (int i = 0; i < plen; i++)
                if (i != 5)
                    sum ^= pkt[i];
            pkt[5] = sum;
            kind = $urandom_range(0, 19);
            if (kind >= 17)
            begin
                pkt[5] = 8'($urandom);
            end
            else if (kind >= 14)
            begin
                // keep byte 0 intact so framing stays aligned
                pos = $urandom_range(1, plen - 1);
                pkt[pos] ^= 8'h01 << $urandom_range(0, 7);
            end
            for (int i = 0; i < plen; i++)
                send_byte(pkt[i], $urandom, 1'b1);
            sent += plen;
            k++;
            if (k % 5 == 0)
                drain_frames();
        end

        drain_frames();
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
